FILE: sv/teq_pkg.sv
// teq_pkg: shared types and codes of the triple-ended queue.
// Used by teq_ctrl, teq_dpath and triple_ended_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

   localparam int VALUE_W  = 64;
   localparam int INDEX_W  = 10;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH_HEAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_TAIL   = 2'd1;
   localparam logic [OP_W-1:0] OP_PUSH_MIDDLE = 2'd2;
   localparam logic [OP_W-1:0] OP_GET         = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

endpackage

`default_nettype wire

FILE: sv/teq_ctrl.sv
// teq_ctrl: sequencer of the triple-ended queue.
// Issues capture and commit commands to teq_dpath; uses teq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module teq_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output teq_pkg::cmd_type  cmd,
   output logic              busy
);

   teq_pkg::state_type state_ff;
   teq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= teq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = teq_pkg::ST_COMMIT;
            end
         end
         teq_pkg::ST_COMMIT: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
            state_in   = teq_pkg::ST_IDLE;
         end
         default: begin
            state_in = teq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/teq_dpath.sv
// teq_dpath: two ring-buffer halves, their pointers and counts, response register.
// Driven by teq_ctrl commands; uses teq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module teq_dpath #(
   parameter int CAPACITY = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  teq_pkg::cmd_type  cmd,
   input  teq_pkg::req_type  req_data,
   output logic              rsp_valid,
   output teq_pkg::rsp_type  rsp_data
);

   localparam int HALF = (CAPACITY + 1) / 2;
   localparam int PW   = $clog2(HALF);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int EW   = (CW > teq_pkg::INDEX_W) ? CW : teq_pkg::INDEX_W;
   localparam logic [PW:0]   HALF_W = (PW + 1)'(HALF);
   localparam logic [PW-1:0] LAST_P = PW'(HALF - 1);
   localparam logic [EW-1:0] CAP_E  = EW'(CAPACITY);

   function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a,
                                              input logic [PW-1:0] off);
      logic [PW:0] sum;
      sum = {1'b0, a} + {1'b0, off};
      if (sum >= HALF_W) begin
         sum = sum - HALF_W;
      end
      return sum[PW-1:0];
   endfunction

   function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] a);
      return (a == '0) ? LAST_P : a - 1'b1;
   endfunction

   logic [teq_pkg::VALUE_W-1:0] front_mem [HALF];
   logic [teq_pkg::VALUE_W-1:0] back_mem  [HALF];

   logic [PW-1:0] front_start_ff, front_start_in;
   logic [PW-1:0] back_start_ff,  back_start_in;
   logic [CW-1:0] front_count_ff, front_count_in;
   logic [CW-1:0] back_count_ff,  back_count_in;

   teq_pkg::req_type            req_ff;
   logic [teq_pkg::VALUE_W-1:0] front_rd_ff;
   logic [teq_pkg::VALUE_W-1:0] back_rd_ff;
   teq_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff;

   // read side, evaluated on the incoming word
   logic [EW-1:0] cap_idx_e, cap_fc_e, cap_boff_e;
   logic [CW-1:0] fc_m1;
   logic [PW-1:0] front_ra, back_ra;

   always_comb begin
      cap_idx_e  = EW'(req_data.index);
      cap_fc_e   = EW'(front_count_ff);
      cap_boff_e = cap_idx_e - cap_fc_e;
      fc_m1      = front_count_ff - 1'b1;
      if (req_data.operation == teq_pkg::OP_GET) begin
         front_ra = ring_add(front_start_ff, cap_idx_e[PW-1:0]);
         back_ra  = ring_add(back_start_ff, cap_boff_e[PW-1:0]);
      end else begin
         front_ra = ring_add(front_start_ff, fc_m1[PW-1:0]);
         back_ra  = back_start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         front_rd_ff <= front_mem[front_ra];
         back_rd_ff  <= back_mem[back_ra];
      end
   end

   // commit side
   logic [EW-1:0] idx_e, fc_e, total_e;
   logic [CW-1:0] total;
   logic          front_we, back_we;
   logic [PW-1:0] front_wa, back_wa;
   logic [teq_pkg::VALUE_W-1:0] front_wd, back_wd;

   always_comb begin
      total          = front_count_ff + back_count_ff;
      idx_e          = EW'(req_ff.index);
      fc_e           = EW'(front_count_ff);
      total_e        = EW'(total);
      front_start_in = front_start_ff;
      back_start_in  = back_start_ff;
      front_count_in = front_count_ff;
      back_count_in  = back_count_ff;
      front_we       = 1'b0;
      back_we        = 1'b0;
      front_wa       = ring_add(front_start_ff, front_count_ff[PW-1:0]);
      back_wa        = ring_add(back_start_ff, back_count_ff[PW-1:0]);
      front_wd       = req_ff.value;
      back_wd        = req_ff.value;
      rsp_in.read_value = '0;
      rsp_in.status     = teq_pkg::STATUS_OK;
      priority if (req_ff.operation == teq_pkg::OP_GET) begin
         if (idx_e >= total_e) begin
            rsp_in.status = teq_pkg::STATUS_RANGE;
         end else if (idx_e < fc_e) begin
            rsp_in.read_value = front_rd_ff;
         end else begin
            rsp_in.read_value = back_rd_ff;
         end
      end else if (total_e >= CAP_E) begin
         rsp_in.status = teq_pkg::STATUS_FULL;
      end else if (req_ff.operation == teq_pkg::OP_PUSH_HEAD) begin
         front_we       = 1'b1;
         front_wa       = ring_prev(front_start_ff);
         front_start_in = ring_prev(front_start_ff);
         if (front_count_ff > back_count_ff) begin
            back_we       = 1'b1;
            back_wa       = ring_prev(back_start_ff);
            back_wd       = front_rd_ff;
            back_start_in = ring_prev(back_start_ff);
            back_count_in = back_count_ff + 1'b1;
         end else begin
            front_count_in = front_count_ff + 1'b1;
         end
      end else if (req_ff.operation == teq_pkg::OP_PUSH_TAIL) begin
         if (front_count_ff == back_count_ff) begin
            front_we       = 1'b1;
            front_count_in = front_count_ff + 1'b1;
            if (back_count_ff != '0) begin
               front_wd      = back_rd_ff;
               back_we       = 1'b1;
               back_start_in = ring_add(back_start_ff, PW'(1));
            end
         end else begin
            back_we       = 1'b1;
            back_count_in = back_count_ff + 1'b1;
         end
      end else begin
         if (front_count_ff == back_count_ff) begin
            front_we       = 1'b1;
            front_count_in = front_count_ff + 1'b1;
         end else begin
            back_we       = 1'b1;
            back_wa       = ring_prev(back_start_ff);
            back_start_in = ring_prev(back_start_ff);
            back_count_in = back_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && front_we) begin
         front_mem[front_wa] <= front_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && back_we) begin
         back_mem[back_wa] <= back_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_start_ff <= '0;
         back_start_ff  <= '0;
         front_count_ff <= '0;
         back_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            front_start_ff <= front_start_in;
            back_start_ff  <= back_start_in;
            front_count_ff <= front_count_in;
            back_count_ff  <= back_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: sv/triple_ended_queue.sv
// triple_ended_queue: top level, sequencer plus two-half ring datapath.
// Instantiates teq_ctrl and teq_dpath; uses teq_pkg.
//
//   channel   ports                    direction  handshake
//   request   start, busy, req_data    in         taken when start & !busy
//   response  rsp_valid, rsp_data      out        one-cycle strobe, no stall
//
// Each item is captured, then committed: the accepting edge reads both half stores, the
// commit cycle writes up to one entry in each half and updates pointers.
// busy is high for the one commit cycle; the response word strobes on the
// cycle after commit, alongside the next accept.
// Reset clears pointers and counts; stores are not cleared.
// The receiver cannot stall; every response is valid for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module triple_ended_queue #(
   parameter int CAPACITY = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  teq_pkg::req_type  req_data,
   output logic              rsp_valid,
   output teq_pkg::rsp_type  rsp_data
);

   teq_pkg::cmd_type cmd;

   teq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (cmd),
      .busy  (busy)
   );

   teq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_valid)
      else $error("commit not followed by response");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !busy && !rsp_valid)
      else $error("response without accepted word");

   a_resp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response overlaps commit");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == teq_pkg::STATUS_OK ||
                     rsp_data.status == teq_pkg::STATUS_FULL ||
                     (rsp_data.status == teq_pkg::STATUS_RANGE &&
                      rsp_data.read_value == '0)))
      else $error("bad response status");

endmodule

`default_nettype wire

FILE: tb/triple_ended_queue_tb.sv
// triple_ended_queue_tb: self-checking bench for the triple-ended queue.
// Directed then random command words checked against an internal queue predictor;
// depends on teq_pkg and triple_ended_queue.
`timescale 1ns / 1ps

module triple_ended_queue_tb;

   localparam int CAPACITY = 1024;
   localparam int HALF     = (CAPACITY + 1) / 2;
   localparam int PHASE_WORDS = 385;
   localparam int IW       = teq_pkg::INDEX_W;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   teq_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   teq_pkg::rsp_type rsp_data;

   triple_ended_queue #(.CAPACITY(CAPACITY)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: two balanced ring halves
   logic [teq_pkg::VALUE_W-1:0] front_mem [HALF];
   logic [teq_pkg::VALUE_W-1:0] back_mem  [HALF];
   int front_start = 0, front_count = 0, back_start = 0, back_count = 0;

   // newest word at the head, oldest at the tail
   teq_pkg::req_type pending_words  [$];
   teq_pkg::rsp_type expected_words [$];
   int      gen_count = 0;
   int      sender_idle_pct = 0;
   logic    word_taken = 1'b0;
   int      errors = 0;
   int      n_push_ok = 0, n_full = 0, n_get_ok = 0, n_range = 0;

   function automatic int ring(int base, int offset);
      return (base + offset) % HALF;
   endfunction

   function automatic teq_pkg::rsp_type apply_op(teq_pkg::req_type w);
      teq_pkg::rsp_type            r;
      int                          total;
      logic [teq_pkg::VALUE_W-1:0] moved;
      r     = '0;
      total = front_count + back_count;
      if (w.operation == teq_pkg::OP_GET) begin
         if (int'(w.index) >= total) begin
            r.status = teq_pkg::STATUS_RANGE;
         end else if (int'(w.index) < front_count) begin
            r.read_value = front_mem[ring(front_start, int'(w.index))];
         end else begin
            r.read_value = back_mem[ring(back_start, int'(w.index) - front_count)];
         end
      end else if (total >= CAPACITY) begin
         r.status = teq_pkg::STATUS_FULL;
      end else begin
         case (w.operation)
            teq_pkg::OP_PUSH_HEAD: begin
               if (front_count > back_count) begin
                  front_count--;
                  moved = front_mem[ring(front_start, front_count)];
                  back_start = ring(back_start, HALF - 1);
                  back_mem[back_start] = moved;
                  back_count++;
               end
               front_start = ring(front_start, HALF - 1);
               front_mem[front_start] = w.value;
               front_count++;
            end
            teq_pkg::OP_PUSH_TAIL: begin
               if (front_count == back_count && back_count > 0) begin
                  moved = back_mem[back_start];
                  back_start = ring(back_start, 1);
                  back_count--;
                  front_mem[ring(front_start, front_count)] = moved;
                  front_count++;
               end
               if (total == 0) begin
                  front_mem[ring(front_start, front_count)] = w.value;
                  front_count++;
               end else begin
                  back_mem[ring(back_start, back_count)] = w.value;
                  back_count++;
               end
            end
            default: begin
               if (front_count == back_count) begin
                  front_mem[ring(front_start, front_count)] = w.value;
                  front_count++;
               end else begin
                  back_start = ring(back_start, HALF - 1);
                  back_mem[back_start] = w.value;
                  back_count++;
               end
            end
         endcase
      end
      return r;
   endfunction

   task automatic add_word(logic [teq_pkg::OP_W-1:0] op, logic [teq_pkg::VALUE_W-1:0] v,
                           logic [IW-1:0] idx);
      teq_pkg::req_type w;
      w.operation = op;
      w.value     = v;
      w.index     = idx;
      pending_words.push_front(w);
      if (op != teq_pkg::OP_GET && gen_count < CAPACITY) gen_count++;
   endtask

   // driver: holds a word until accepted, then maybe idles
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data <= pending_words.pop_back();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check the strobed response, then predict the accepted word
   always @(posedge clock) begin
      teq_pkg::rsp_type e;
      word_taken <= !reset && start && !busy;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word %h", $time, rsp_data);
         end else begin
            e = expected_words.pop_back();
            if (rsp_data.read_value !== e.read_value) begin
               errors++;
               $display("%0t: read_value expected %h actual %h",
                        $time, e.read_value, rsp_data.read_value);
            end
            if (rsp_data.status !== e.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d",
                        $time, e.status, rsp_data.status);
            end
         end
      end
      if (!reset && start && busy === 1'b0) begin
         e = apply_op(req_data);
         expected_words.push_front(e);
         if (e.status == teq_pkg::STATUS_FULL) n_full++;
         else if (e.status == teq_pkg::STATUS_RANGE) n_range++;
         else if (req_data.operation == teq_pkg::OP_GET) n_get_ok++;
         else n_push_ok++;
      end
   end

   initial begin
      int phase_idle [4];
      int r;
      int sel;
      logic [teq_pkg::VALUE_W-1:0] v;
      logic [IW-1:0]               idx;
      logic [teq_pkg::OP_W-1:0]    op;
      phase_idle = '{0, 49, 0, 27};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty gets, first pushes, extremes, boundary gets
      add_word(teq_pkg::OP_GET,         '0,  '0);
      add_word(teq_pkg::OP_GET,         '0,  '1);
      add_word(teq_pkg::OP_PUSH_MIDDLE, '1,  '0);
      add_word(teq_pkg::OP_GET,         '0,  '0);
      add_word(teq_pkg::OP_PUSH_TAIL,   '0,  '1);
      add_word(teq_pkg::OP_PUSH_TAIL,   64'h0123_4567_89ab_cdef, '0);
      add_word(teq_pkg::OP_PUSH_HEAD,   64'hfedc_ba98_7654_3210, '0);
      add_word(teq_pkg::OP_PUSH_MIDDLE, 64'h5555_5555_5555_5555, '0);
      add_word(teq_pkg::OP_PUSH_MIDDLE, 64'haaaa_aaaa_aaaa_aaaa, '0);
      add_word(teq_pkg::OP_PUSH_HEAD,   '0,  '0);
      add_word(teq_pkg::OP_PUSH_TAIL,   '1,  '0);
      add_word(teq_pkg::OP_GET,         '0,  10'd0);
      add_word(teq_pkg::OP_GET,         '0,  10'd4);
      add_word(teq_pkg::OP_GET,         '0,  10'd8);
      add_word(teq_pkg::OP_GET,         '0,  10'd9);
      add_word(teq_pkg::OP_GET,         '0,  10'd5);
      add_word(teq_pkg::OP_GET,         '0,  '1);

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = phase_idle[p];
         for (int i = 0; i < PHASE_WORDS; i++) begin
            r = $urandom_range(99);
            sel = $urandom_range(15);
            v = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
            if (r < 28) begin
               sel = $urandom_range(9);
               if (gen_count > 0 && sel < 8) idx = IW'($urandom_range(gen_count - 1));
               else if (sel == 8) idx = IW'(gen_count);
               else idx = IW'($urandom);
               add_word(teq_pkg::OP_GET, v, idx);
            end else begin
               sel = $urandom_range(2);
               if (sel == 0) op = teq_pkg::OP_PUSH_HEAD;
               else if (sel == 1) op = teq_pkg::OP_PUSH_TAIL;
               else op = teq_pkg::OP_PUSH_MIDDLE;
               add_word(op, v, IW'($urandom));
            end
         end
         while (pending_words.size() > 0 || start || expected_words.size() > 0)
            @(posedge clock);
      end

      repeat (6) @(posedge clock);
      if (expected_words.size() > 0) begin
         errors++;
         $display("%0t: %0d response words never arrived", $time, expected_words.size());
      end
      $display("Covered %0d good pushes, %0d pushes dropped when full,", n_push_ok, n_full);
      $display("%0d good gets, %0d out-of-range gets; %0d errors.", n_get_ok, n_range, errors);
      if (errors == 0) begin
         $display("PASS triple_ended_queue");
      end else begin
         $display("FAIL triple_ended_queue");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL triple_ended_queue");
      $finish;
   end

endmodule

FILE: triple_ended_queue.f
sv/teq_pkg.sv
sv/teq_ctrl.sv
sv/teq_dpath.sv
sv/triple_ended_queue.sv
tb/triple_ended_queue_tb.sv
